>>> hw/rtl/coap_message_stream_parser_macros.svh
// Assertion macros shared by the CoAP stream parser RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COAP_MESSAGE_STREAM_PARSER_MACROS_SVH
`define COAP_MESSAGE_STREAM_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset (reset active low)
`define CMSP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CMSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CMSP_ASSERT_RST(label, clk, rst_n, prop, msg)
`define CMSP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> hw/rtl/cmsp_pkg.sv
// Types, codes and helpers for the CoAP message stream parser.
// No dependencies; imported by cmsp_byte_step, the top level and the testbench.
package cmsp_pkg;

    localparam int unsigned MAX_TOKEN_RESET = 8;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TOKEN   = 3'd1,
        PH_OPTHDR  = 3'd2,
        PH_OPTVAL  = 3'd3,
        PH_MARKED  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_STOPPED = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRUNC   = 3'd1,
        ST_VERSION = 3'd2,
        ST_TOKEN   = 3'd3,
        ST_OPTION  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_TOKEN   = 3'd1,
        KIND_OPTHDR  = 3'd2,
        KIND_OPTVAL  = 3'd3,
        KIND_MARKER  = 3'd4,
        KIND_PAYLOAD = 3'd5,
        KIND_IGNORED = 3'd6
    } t_kind;

    localparam logic [1:0] HDR_VERSION   = 2'd1;
    localparam logic [3:0] NIBBLE_EXT    = 4'hF;
    localparam logic [7:0] PAYLOAD_MARK  = 8'hFF;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hdr_pos;
        logic [3:0]  remaining;
        logic [15:0] opt_num;
        logic [3:0]  opt_len;
        logic [1:0]  msg_type;
        logic [3:0]  tok_len;
        logic [7:0]  code;
        logic [15:0] msg_id;
        t_status     status;
    } t_msg_state;

    function automatic t_msg_state msg_clear();
        t_msg_state s;
        s = '0;
        s.phase  = PH_HEADER;
        s.status = ST_OK;
        return s;
    endfunction

endpackage

>>> hw/rtl/cmsp_byte_step.sv
// One-byte parse step of the CoAP stream parser: header, token, options, payload.
// Depends on cmsp_pkg.
module cmsp_byte_step (
    input  cmsp_pkg::t_msg_state i_state,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [3:0]           i_max_tok,
    output cmsp_pkg::t_msg_state o_post,   // state as reported for this byte
    output cmsp_pkg::t_msg_state o_next,   // state kept for the next byte
    output cmsp_pkg::t_kind      o_kind
);
    import cmsp_pkg::*;

    t_msg_state s;
    logic [3:0] delta;
    logic [3:0] len;

    assign delta = i_byte[7:4];
    assign len   = i_byte[3:0];

    always_comb begin
        s      = i_state;
        o_kind = KIND_IGNORED;
        case (i_state.phase)
            PH_HEADER: begin
                o_kind = KIND_HEADER;
                case (i_state.hdr_pos)
                    2'd0: begin
                        s.msg_type = i_byte[5:4];
                        s.tok_len  = i_byte[3:0];
                        if (i_byte[7:6] != HDR_VERSION) begin
                            s.status = ST_VERSION;
                        end
                        s.hdr_pos = 2'd1;
                    end
                    2'd1: begin
                        s.code    = i_byte;
                        s.hdr_pos = 2'd2;
                    end
                    2'd2: begin
                        s.msg_id  = {i_byte, 8'h00};
                        s.hdr_pos = 2'd3;
                    end
                    default: begin
                        s.msg_id  = {i_state.msg_id[15:8], i_byte};
                        s.hdr_pos = 2'd0;
                        if (i_state.status != ST_OK) begin
                            s.phase = PH_STOPPED;
                        end else if (i_state.tok_len > i_max_tok) begin
                            s.status = ST_TOKEN;
                            s.phase  = PH_STOPPED;
                        end else if (i_state.tok_len != 4'd0) begin
                            s.remaining = i_state.tok_len;
                            s.phase     = PH_TOKEN;
                        end else begin
                            s.phase = PH_OPTHDR;
                        end
                    end
                endcase
            end
            PH_TOKEN: begin
                o_kind      = KIND_TOKEN;
                s.remaining = i_state.remaining - 4'd1;
                if (s.remaining == 4'd0) begin
                    s.phase = PH_OPTHDR;
                end
            end
            PH_OPTHDR: begin
                if (i_byte == PAYLOAD_MARK) begin
                    o_kind  = KIND_MARKER;
                    s.phase = PH_MARKED;
                end else begin
                    o_kind = KIND_OPTHDR;
                    if (delta == NIBBLE_EXT || len == NIBBLE_EXT) begin
                        s.status = ST_OPTION;
                        s.phase  = PH_STOPPED;
                    end else begin
                        s.opt_num   = i_state.opt_num + {12'd0, delta};
                        s.opt_len   = len;
                        s.remaining = len;
                        s.phase     = (len != 4'd0) ? PH_OPTVAL : PH_OPTHDR;
                    end
                end
            end
            PH_OPTVAL: begin
                o_kind      = KIND_OPTVAL;
                s.remaining = i_state.remaining - 4'd1;
                if (s.remaining == 4'd0) begin
                    s.phase = PH_OPTHDR;
                end
            end
            PH_MARKED, PH_PAYLOAD: begin
                o_kind  = KIND_PAYLOAD;
                s.phase = PH_PAYLOAD;
            end
            default: begin
                o_kind = KIND_IGNORED;
            end
        endcase

        // truncation is judged only on the end byte; a short header wins over all
        if (i_last) begin
            if (s.phase == PH_HEADER) begin
                s.status = ST_TRUNC;
            end else if (s.status == ST_OK && (s.phase == PH_TOKEN ||
                         s.phase == PH_OPTVAL || s.phase == PH_MARKED)) begin
                s.status = ST_TRUNC;
            end
        end

        o_post = s;
        o_next = i_last ? msg_clear() : s;
    end

endmodule

>>> hw/rtl/coap_message_stream_parser.sv
// Top level of the CoAP message stream parser: stream ports, state and result registers.
// Depends on cmsp_pkg, cmsp_byte_step and coap_message_stream_parser_macros.svh.
//
// Takes one datagram byte per cycle unless stalled and returns one result per byte
// in the next cycle. The parse step for a byte is combinational logic from the message
// state registers into the result register, so a byte is accepted every cycle
// as long as the result register is empty or being drained in the same cycle;
// o_s_tready drops only while a result waits on i_m_tready. The byte with tlast
// set carries the final status (o_m_tlast) and clears the message state.
// max_token_length is written through the cfg channel, which is always ready.
module coap_message_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,    // max_token_length
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] data_byte
    input  logic        i_s_tlast,     // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] byte_value, [23:8] option_number, [27:24] option_length,
    // [29:28] message_type, [33:30] token_length, [41:34] message_code,
    // [57:42] msg_id, [60:58] parse_status, [63:61] zero
    output logic [63:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,     // [2:0] byte_kind
    output logic        o_m_tlast      // message_done
);
    import cmsp_pkg::*;

    logic [3:0] r_max_tok;
    t_msg_state r_state;
    t_msg_state n_state;
    t_msg_state w_post;
    t_kind      w_kind;

    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    t_msg_state r_out_state;

    logic       w_in_req;

    cmsp_byte_step u_step (
        .i_state   (r_state),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_max_tok (r_max_tok),
        .o_post    (w_post),
        .o_next    (n_state),
        .o_kind    (w_kind)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_in_req    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tok <= 4'(MAX_TOKEN_RESET);
        end else if (i_cfg_valid) begin
            r_max_tok <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msg_clear();
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_req) begin
                r_state <= n_state;
            end
            if (w_in_req) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_out_kind  <= w_kind;
            r_out_byte  <= i_s_tdata;
            r_out_last  <= i_s_tlast;
            r_out_state <= w_post;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {3'd0,
                         r_out_state.status,
                         r_out_state.msg_id,
                         r_out_state.code,
                         r_out_state.tok_len,
                         r_out_state.msg_type,
                         r_out_state.opt_len,
                         r_out_state.opt_num,
                         r_out_byte};

`include "coap_message_stream_parser_macros.svh"

    `CMSP_ASSERT_RST(a_status_sticky, i_clk, i_rst_n,
        (w_in_req && !i_s_tlast && r_state.status != ST_OK)
        |=> (r_state.status == $past(r_state.status)),
        "status changed within a message")
    `CMSP_ASSERT_RST(a_clear_after_end, i_clk, i_rst_n,
        (w_in_req && i_s_tlast) |=> (r_state.phase == PH_HEADER &&
        r_state.hdr_pos == 2'd0 && r_state.status == ST_OK),
        "state not cleared after end byte")
    `CMSP_ASSERT_RST(a_stopped_has_error, i_clk, i_rst_n,
        (r_state.phase == PH_STOPPED) |-> (r_state.status != ST_OK),
        "stopped without error status")
    `CMSP_ASSERT_RST(a_ignored_has_error, i_clk, i_rst_n,
        (o_m_tvalid && o_m_tuser == KIND_IGNORED) |-> (o_m_tdata[60:58] != ST_OK),
        "ignored byte with ok status")

endmodule

>>> tb/coap_message_stream_parser_tb.sv
// Self-checking testbench for coap_message_stream_parser: directed and random datagrams,
// each result checked against a per-byte parse model kept in a small scoreboard class.
// Depends on cmsp_pkg and the parser RTL.
module coap_message_stream_parser_tb;
    import cmsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] opt_num;
        logic [3:0]  opt_len;
        logic [1:0]  msg_type;
        logic [3:0]  tok_len;
        logic [7:0]  code;
        logic [15:0] msg_id;
        t_status     status;
        logic        done;
    } t_parse_result;

    class coap_parse_scoreboard;
        logic [3:0]    max_token;
        t_phase        phase;
        logic [1:0]    hdr_pos;
        logic [3:0]    remaining;
        logic [15:0]   opt_num;
        logic [3:0]    opt_len;
        logic [1:0]    msg_type;
        logic [3:0]    tok_len;
        logic [7:0]    code;
        logic [15:0]   msg_id;
        t_status       status;
        t_parse_result pending[$];
        int unsigned   errors;

        function new();
            max_token = 4'(MAX_TOKEN_RESET);
            errors = 0;
            clear_message();
        endfunction

        function void clear_message();
            phase = PH_HEADER;
            hdr_pos = '0;
            remaining = '0;
            opt_num = '0;
            opt_len = '0;
            msg_type = '0;
            tok_len = '0;
            code = '0;
            msg_id = '0;
            status = ST_OK;
        endfunction

        function string show(t_parse_result r);
            return $sformatf({"kind=%0d byte=%02h opt=%0d len=%0d type=%0d tkl=%0d",
                              " code=%02h id=%04h status=%0d done=%0b"},
                             r.kind, r.data_byte, r.opt_num, r.opt_len, r.msg_type,
                             r.tok_len, r.code, r.msg_id, r.status, r.done);
        endfunction

        // advance the parse by one accepted byte and queue the result it must give
        function void note_byte(logic [7:0] data_byte, logic last);
            t_parse_result r;
            t_kind         kind;
            kind = KIND_IGNORED;
            case (phase)
                PH_HEADER: begin
                    kind = KIND_HEADER;
                    case (hdr_pos)
                        2'd0: begin
                            msg_type = data_byte[5:4];
                            tok_len = data_byte[3:0];
                            if (data_byte[7:6] != HDR_VERSION) status = ST_VERSION;
                            hdr_pos = 2'd1;
                        end
                        2'd1: begin
                            code = data_byte;
                            hdr_pos = 2'd2;
                        end
                        2'd2: begin
                            msg_id = {data_byte, 8'h00};
                            hdr_pos = 2'd3;
                        end
                        default: begin
                            msg_id[7:0] = data_byte;
                            hdr_pos = 2'd0;
                            if (status != ST_OK) begin
                                phase = PH_STOPPED;
                            end else if (tok_len > max_token) begin
                                status = ST_TOKEN;
                                phase = PH_STOPPED;
                            end else if (tok_len != 0) begin
                                remaining = tok_len;
                                phase = PH_TOKEN;
                            end else begin
                                phase = PH_OPTHDR;
                            end
                        end
                    endcase
                end
                PH_TOKEN: begin
                    kind = KIND_TOKEN;
                    remaining = remaining - 4'd1;
                    if (remaining == 0) phase = PH_OPTHDR;
                end
                PH_OPTHDR: begin
                    if (data_byte == PAYLOAD_MARK) begin
                        kind = KIND_MARKER;
                        phase = PH_MARKED;
                    end else begin
                        kind = KIND_OPTHDR;
                        if (data_byte[7:4] == NIBBLE_EXT || data_byte[3:0] == NIBBLE_EXT) begin
                            status = ST_OPTION;
                            phase = PH_STOPPED;
                        end else begin
                            opt_num = opt_num + 16'(data_byte[7:4]);
                            opt_len = data_byte[3:0];
                            remaining = data_byte[3:0];
                            phase = (data_byte[3:0] != 0) ? PH_OPTVAL : PH_OPTHDR;
                        end
                    end
                end
                PH_OPTVAL: begin
                    kind = KIND_OPTVAL;
                    remaining = remaining - 4'd1;
                    if (remaining == 0) phase = PH_OPTHDR;
                end
                PH_MARKED, PH_PAYLOAD: begin
                    kind = KIND_PAYLOAD;
                    phase = PH_PAYLOAD;
                end
                default: ;
            endcase

            // a short header always reads as truncated; otherwise only an owed byte does
            if (last) begin
                if (phase == PH_HEADER)
                    status = ST_TRUNC;
                else if (status == ST_OK &&
                         (phase == PH_TOKEN || phase == PH_OPTVAL || phase == PH_MARKED))
                    status = ST_TRUNC;
            end

            r.kind = kind;
            r.data_byte = data_byte;
            r.opt_num = opt_num;
            r.opt_len = opt_len;
            r.msg_type = msg_type;
            r.tok_len = tok_len;
            r.code = code;
            r.msg_id = msg_id;
            r.status = status;
            r.done = last;
            pending.push_back(r);
            if (last) clear_message();
        endfunction

        function void check_result(logic [2:0] kind, logic [63:0] data, logic done);
            t_parse_result got;
            t_parse_result exp;
            got.kind = t_kind'(kind);
            got.data_byte = data[7:0];
            got.opt_num = data[23:8];
            got.opt_len = data[27:24];
            got.msg_type = data[29:28];
            got.tok_len = data[33:30];
            got.code = data[41:34];
            got.msg_id = data[57:42];
            got.status = t_status'(data[60:58]);
            got.done = done;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with no byte pending: %s", show(got));
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch, expected: %s", show(exp));
                    $display("mismatch, actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    coap_parse_scoreboard sb = new();
    logic [7:0]  msg_bytes[$];
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;

    coap_message_stream_parser i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // result side backpressure in bursts
    always @(negedge clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] data_byte, input logic last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data_byte;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(data_byte, last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        bytes_sent += msg_bytes.size();
    endtask

    // drop the request and wait for every outstanding result
    task automatic drain();
        @(negedge clk) s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_max_token(input logic [3:0] limit);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        do @(posedge clk); while (!cfg_ready);
        sb.max_token = limit;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // mostly well-formed datagrams; the rest truncated, bad version, long token,
    // extended option nibble or plain noise
    function automatic void build_message(input logic [3:0] tok_max);
        int unsigned shape;
        int unsigned cut;
        logic [3:0]  tkl;
        logic [3:0]  len;
        logic [1:0]  ver;
        shape = $urandom_range(0, 11);
        msg_bytes.delete();
        if (shape == 11) begin
            repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
            return;
        end
        tkl = 4'($urandom_range(0, tok_max));
        msg_bytes.push_back({HDR_VERSION, 2'($urandom_range(0, 3)), tkl});
        repeat (3 + tkl) msg_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
            len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 14))
                                               : 4'($urandom_range(0, 3));
            msg_bytes.push_back({4'($urandom_range(0, 14)), len});
            repeat (len) msg_bytes.push_back(8'($urandom));
        end
        if (shape == 10) begin
            msg_bytes.push_back($urandom_range(0, 1) ? {NIBBLE_EXT, 4'($urandom_range(0, 14))}
                                                     : {4'($urandom_range(0, 14)), NIBBLE_EXT});
            repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 1)) begin
            msg_bytes.push_back(PAYLOAD_MARK);
            repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom));
        end
        case (shape)
            7: begin
                if (msg_bytes.size() > 1) begin
                    cut = $urandom_range(1, msg_bytes.size() - 1);
                    repeat (cut) void'(msg_bytes.pop_back());
                end
            end
            8: begin
                do ver = 2'($urandom); while (ver == HDR_VERSION);
                msg_bytes[0] = {ver, msg_bytes[0][5:0]};
            end
            9: begin
                if (tok_max != 4'hF)
                    msg_bytes[0] = {msg_bytes[0][7:4], 4'($urandom_range(tok_max + 1, 15))};
            end
            default: ;
        endcase
    endfunction

    initial begin
        logic [3:0] tok_cfg;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed, reset token limit of 8
        msg_bytes = '{8'h52, 8'h45, 8'h12, 8'h34, 8'h00, 8'hFF, 8'h11, 8'hAA, 8'hFF, 8'h00};
        send_message();
        msg_bytes = '{8'hC0, 8'h01, 8'h02, 8'h03, 8'h55};
        send_message();
        msg_bytes = '{8'h79, 8'hFF, 8'hFF, 8'hFF};
        send_message();
        msg_bytes = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h1F};
        send_message();
        msg_bytes = '{8'h00};
        send_message();
        drain();

        for (int p = 0; p < 5; p++) begin
            tok_cfg = (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : 4'($urandom);
            idle_on = (p != 4);
            write_max_token(tok_cfg);
            bytes_sent = 0;
            while (bytes_sent < 80) begin
                build_message(tok_cfg);
                send_message();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
